/* rtl/msa_pkg.sv */
package msa_pkg;

    localparam int DATA_W = 32;

    typedef logic signed [DATA_W-1:0] t_data;

    typedef struct packed {
        t_data value;
        logic  last;
    } t_in_item;

    typedef struct packed {
        t_data sorted_value;
        logic  last_out;
        logic  overflowed;
    } t_out_item;

endpackage

/* rtl/msa_if.sv */
interface msa_in_if import msa_pkg::*; ();
    logic     valid;
    logic     ready;
    t_in_item data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface msa_out_if import msa_pkg::*; ();
    logic      valid;
    logic      ready;
    t_out_item data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

/* rtl/msa_bank.sv */
// One write port, two registered read ports.
module msa_bank
    import msa_pkg::*;
#(
    parameter int DEPTH = 64,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  t_data         i_wdata,
    input  logic [AW-1:0] i_raddr_a,
    input  logic [AW-1:0] i_raddr_b,
    output t_data         o_rdata_a,
    output t_data         o_rdata_b
);

    t_data r_mem [DEPTH];
    t_data r_rdata_a;
    t_data r_rdata_b;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata_a <= r_mem[i_raddr_a];
        r_rdata_b <= r_mem[i_raddr_b];
    end

    assign o_rdata_a = r_rdata_a;
    assign o_rdata_b = r_rdata_b;

endmodule

/* rtl/merge_sort_array_top.sv */
// Channel | Dir | Payload                                | Accepted when
// i_in    | in  | value (s32), last                       | valid && ready
// o_out   | out | sorted_value (s32), last_out, overflowed | valid && ready
//
// Load takes one item per cycle; ready is high only while loading.
// A batch of n items then takes ceil(log2 n) merge passes, each a read / compare /
// write loop over the two memory banks, and each result on the way out is read
// from the bank and then offered.
// Reset is synchronous, active low; memories need no clearing.
// A stalled result holds in the bank's read register until it is taken.
module merge_sort_array_top
    import msa_pkg::*;
#(
    parameter int MAX_ELEMS = 64
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    msa_in_if.sink       i_in,
    msa_out_if.source    o_out
);

    localparam int AW = (MAX_ELEMS > 1) ? $clog2(MAX_ELEMS) : 1;
    localparam int CW = $clog2(MAX_ELEMS + 1);   // counts 0..MAX_ELEMS
    localparam int XW = CW + 2;                  // room for lo + 2*width

    localparam logic [2:0] S_LOAD = 3'd0;
    localparam logic [2:0] S_MRD  = 3'd1;
    localparam logic [2:0] S_MWR  = 3'd2;
    localparam logic [2:0] S_ORD  = 3'd3;
    localparam logic [2:0] S_OVAL = 3'd4;

    localparam logic [CW-1:0] CNT_MAX = CW'(MAX_ELEMS);

    logic [2:0]    r_state, n_state;
    logic [CW-1:0] r_fill,  n_fill;    // batch size n once loading ends
    logic          r_ovf,   n_ovf;
    logic          r_src,   n_src;     // bank holding the current runs
    logic [CW-1:0] r_i, n_i, r_j, n_j, r_k, n_k;
    logic [CW-1:0] r_mid, n_mid, r_hi, n_hi;
    logic [XW-1:0] r_w, n_w;           // run width of this pass

    t_data b0_a, b0_b, b1_a, b1_b;
    t_data src_a, src_b, sel_data;
    logic  load_we, merge_we, take_left, full;
    logic  we0, we1;
    logic [AW-1:0] waddr, raddr_a, raddr_b;
    t_data wdata;

    // clamp to batch size
    function automatic logic [CW-1:0] clamp_n(input logic [XW-1:0] x,
                                              input logic [CW-1:0] n);
        logic [XW-1:0] nx;
        nx = XW'(n);
        return (x > nx) ? n : x[CW-1:0];
    endfunction

    assign full     = (r_fill == CNT_MAX);
    assign load_we  = (r_state == S_LOAD) && i_in.valid && !full;
    assign merge_we = (r_state == S_MWR);

    assign src_a = r_src ? b1_a : b0_a;
    assign src_b = r_src ? b1_b : b0_b;

    // left wins on equal keys: stable
    assign take_left = (r_i < r_mid) && ((r_j >= r_hi) || (src_a <= src_b));
    assign sel_data  = take_left ? src_a : src_b;

    assign raddr_a = (r_state == S_MRD) ? r_i[AW-1:0] : r_k[AW-1:0];
    assign raddr_b = r_j[AW-1:0];
    assign waddr   = load_we ? r_fill[AW-1:0] : r_k[AW-1:0];
    assign wdata   = load_we ? i_in.data.value : sel_data;
    assign we0     = load_we || (merge_we && r_src);
    assign we1     = merge_we && !r_src;

    msa_bank #(.DEPTH(MAX_ELEMS), .AW(AW)) u_bank0 (
        .i_clk     (i_clk),
        .i_we      (we0),
        .i_waddr   (waddr),
        .i_wdata   (wdata),
        .i_raddr_a (raddr_a),
        .i_raddr_b (raddr_b),
        .o_rdata_a (b0_a),
        .o_rdata_b (b0_b)
    );

    msa_bank #(.DEPTH(MAX_ELEMS), .AW(AW)) u_bank1 (
        .i_clk     (i_clk),
        .i_we      (we1),
        .i_waddr   (waddr),
        .i_wdata   (wdata),
        .i_raddr_a (raddr_a),
        .i_raddr_b (raddr_b),
        .o_rdata_a (b1_a),
        .o_rdata_b (b1_b)
    );

    always_comb begin
        logic [CW-1:0] fill_nx;
        logic [CW-1:0] k1;
        logic [XW-1:0] w2;
        n_state = r_state;
        n_fill  = r_fill;
        n_ovf   = r_ovf;
        n_src   = r_src;
        n_i     = r_i;
        n_j     = r_j;
        n_k     = r_k;
        n_mid   = r_mid;
        n_hi    = r_hi;
        n_w     = r_w;
        fill_nx = r_fill + CW'(!full);
        k1      = r_k + CW'(1);
        w2      = r_w << 1;
        case (r_state)
            S_LOAD: begin
                if (i_in.valid) begin
                    n_fill = fill_nx;
                    n_ovf  = r_ovf | full;
                    if (i_in.data.last) begin
                        n_src = 1'b0;
                        n_k   = '0;
                        n_i   = '0;
                        if (fill_nx > CW'(1)) begin
                            // first pass: runs of one
                            n_w     = XW'(1);
                            n_j     = CW'(1);
                            n_mid   = CW'(1);
                            n_hi    = clamp_n(XW'(2), fill_nx);
                            n_state = S_MRD;
                        end else begin
                            n_state = S_ORD;
                        end
                    end
                end
            end
            S_MRD: begin
                n_state = S_MWR;
            end
            S_MWR: begin
                if (take_left) begin
                    n_i = r_i + CW'(1);
                end else begin
                    n_j = r_j + CW'(1);
                end
                n_state = S_MRD;
                if (k1 == r_fill) begin
                    // pass done: roles of the banks swap
                    n_src = !r_src;
                    n_w   = w2;
                    n_k   = '0;
                    n_i   = '0;
                    if (w2 >= XW'(r_fill)) begin
                        n_state = S_ORD;
                    end else begin
                        n_mid = clamp_n(w2, r_fill);
                        n_j   = clamp_n(w2, r_fill);
                        n_hi  = clamp_n(w2 << 1, r_fill);
                    end
                end else begin
                    n_k = k1;
                    if (k1 == r_hi) begin
                        // next pair of runs; a lone tail run is copied
                        n_i   = k1;
                        n_mid = clamp_n(XW'(k1) + r_w, r_fill);
                        n_j   = clamp_n(XW'(k1) + r_w, r_fill);
                        n_hi  = clamp_n(XW'(k1) + (r_w << 1), r_fill);
                    end
                end
            end
            S_ORD: begin
                n_state = S_OVAL;
            end
            S_OVAL: begin
                if (o_out.ready) begin
                    if (k1 == r_fill) begin
                        n_fill  = '0;
                        n_ovf   = 1'b0;
                        n_state = S_LOAD;
                    end else begin
                        n_k     = k1;
                        n_state = S_ORD;
                    end
                end
            end
            default: begin
                n_state = S_LOAD;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_LOAD;
            r_fill  <= '0;
            r_ovf   <= 1'b0;
            r_src   <= 1'b0;
        end else begin
            r_state <= n_state;
            r_fill  <= n_fill;
            r_ovf   <= n_ovf;
            r_src   <= n_src;
        end
        r_i   <= n_i;
        r_j   <= n_j;
        r_k   <= n_k;
        r_mid <= n_mid;
        r_hi  <= n_hi;
        r_w   <= n_w;
    end

    assign i_in.ready              = (r_state == S_LOAD);
    assign o_out.valid             = (r_state == S_OVAL);
    assign o_out.data.sorted_value = src_a;
    assign o_out.data.last_out     = ((r_k + CW'(1)) == r_fill);
    assign o_out.data.overflowed   = r_ovf;

endmodule

/* tb/sv/tb_merge_sort_array_top.sv */
`timescale 1ns / 100ps

module tb_merge_sort_array_top;
    import msa_pkg::*;

    localparam int CAPACITY    = 64;
    localparam int CLK_HALF    = 2;
    localparam int RESET_CYC   = 12;
    // Long output hold; well past the sort time of the batches sent under it
    localparam int LONG_HOLD   = 1500;
    localparam int ITEM_GOAL   = 400;
    // Watchdog limit; keep a wide margin over the slowest run
    localparam int LIMIT_CYC   = 300000;
    localparam int DRAIN_CYC   = 64;
    localparam int MAX_REPORTS = 40;

    localparam t_data S32_MIN = {1'b1, {(DATA_W-1){1'b0}}};
    localparam t_data S32_MAX = {1'b0, {(DATA_W-1){1'b1}}};

    // Output-side ready behavior; a new mode is drawn when the current one runs out
    typedef enum int {RX_OPEN, RX_RANDOM, RX_PERIODIC, RX_SPARSE} t_rx_mode;

    // Value shapes for random batches
    typedef enum int {
        VAL_FULL, VAL_DUPS, VAL_EXTREMES, VAL_ASCENDING, VAL_DESCENDING
    } t_val_shape;

    logic i_clk = 1'b0;
    logic i_rst_n;

    msa_in_if  in_ch ();
    msa_out_if out_ch ();

    merge_sort_array_top #(
        .MAX_ELEMS (CAPACITY)
    ) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    always begin
        #CLK_HALF i_clk = 1'b1;
        #CLK_HALF i_clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Predictor state: values held for the batch being loaded, plus the
    // sorted results still owed by the block, oldest first.
    // ------------------------------------------------------------------
    t_data     held_vals [CAPACITY];
    int        held_count   = 0;
    logic      held_dropped = 1'b0;
    t_out_item sorted_q [$];

    int err_count     = 0;
    int items_sent    = 0;
    int burst_left    = 0;
    int hold_requests = 0;

    // Bottom-up two-way merge sort of the first n held values.
    // Ties take the left run first, so the sort is stable.
    function automatic void sort_held(int n);
        t_data merged [CAPACITY];
        int    lo, mid, hi, i, j, k;
        for (int w = 1; w < n; w = w * 2) begin
            for (lo = 0; lo + w < n; lo = lo + 2 * w) begin
                mid = lo + w;
                hi  = (mid + w > n) ? n : mid + w;
                i   = lo;
                j   = mid;
                for (k = lo; k < hi; k++) begin
                    if (j >= hi || (i < mid && held_vals[i] <= held_vals[j])) begin
                        merged[k] = held_vals[i];
                        i++;
                    end else begin
                        merged[k] = held_vals[j];
                        j++;
                    end
                end
                for (k = lo; k < hi; k++)
                    held_vals[k] = merged[k];
            end
        end
    endfunction

    // Account for one accepted input item. A full store drops the value
    // and marks the batch; the item flagged last closes the batch even
    // when its own value was dropped.
    function automatic void absorb_item(t_in_item it);
        t_out_item res;
        if (held_count < CAPACITY) begin
            held_vals[held_count] = it.value;
            held_count++;
        end else begin
            held_dropped = 1'b1;
        end
        if (it.last) begin
            sort_held(held_count);
            for (int k = 0; k < held_count; k++) begin
                res.sorted_value = held_vals[k];
                res.last_out     = (k == held_count - 1);
                res.overflowed   = held_dropped;
                sorted_q.push_back(res);
            end
            held_count   = 0;
            held_dropped = 1'b0;
        end
    endfunction

    task automatic report_mismatch(input string msg);
        err_count++;
        if (err_count <= MAX_REPORTS)
            $display("[%0t] mismatch: %s", $time, msg);
    endtask

    // ------------------------------------------------------------------
    // Input side. Items go out in bursts of random length; between bursts
    // valid drops for a random gap (sometimes none at all). The task
    // returns in the time step of the edge that accepted the item.
    // ------------------------------------------------------------------
    task automatic send_item(input t_data v, input logic lst);
        t_in_item it;
        int       gap;
        it.value = v;
        it.last  = lst;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0) begin
                in_ch.valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            burst_left = $urandom_range(1, 24);
        end
        in_ch.valid <= 1'b1;
        in_ch.data  <= it;
        do @(posedge i_clk); while (in_ch.ready !== 1'b1);
        absorb_item(it);
        items_sent++;
        burst_left--;
    endtask

    task automatic send_batch(input t_data vals [$]);
        foreach (vals[k])
            send_item(vals[k], k == vals.size() - 1);
    endtask

    // Sender goes quiet until every owed result has been taken
    task automatic wait_drained();
        in_ch.valid <= 1'b0;
        do @(posedge i_clk); while (sorted_q.size() != 0);
    endtask

    function automatic t_data pick_value(t_val_shape shape);
        t_data pool [7];
        pool = '{S32_MIN, S32_MAX, 0, -1, 1, S32_MIN + 1, S32_MAX - 1};
        case (shape)
            VAL_DUPS:     return t_data'($urandom_range(0, 8)) - 4;
            VAL_EXTREMES: return pool[$urandom_range(0, 6)];
            default:      return t_data'($urandom);
        endcase
    endfunction

    function automatic void fill_random(ref t_data vals [$], input int n, input t_val_shape shape);
        vals.delete();
        for (int k = 0; k < n; k++)
            vals.push_back(pick_value(shape));
        if (shape == VAL_ASCENDING)
            vals.sort();
        else if (shape == VAL_DESCENDING)
            vals.rsort();
    endfunction

    // ------------------------------------------------------------------
    // Output side. Ready follows a mode that is drawn anew when its random
    // stretch runs out; a long hold requested by a test overrides it and is counted
    // down here, cycle by cycle.
    // ------------------------------------------------------------------
    t_rx_mode rx_mode    = RX_OPEN;
    int       rx_left    = 0;
    int       rx_phase   = 0;
    int       hold_left  = 0;
    int       holds_done = 0;

    always @(posedge i_clk) begin
        if (hold_left > 0) begin
            out_ch.ready <= 1'b0;
            hold_left--;
        end else if (holds_done != hold_requests) begin
            holds_done++;
            hold_left = LONG_HOLD - 1;
            out_ch.ready <= 1'b0;
        end else begin
            if (rx_left == 0) begin
                rx_mode = t_rx_mode'($urandom_range(0, 3));
                rx_left = $urandom_range(32, 256);
            end
            rx_left--;
            rx_phase++;
            case (rx_mode)
                RX_OPEN:     out_ch.ready <= 1'b1;
                RX_RANDOM:   out_ch.ready <= ($urandom_range(0, 3) != 0);
                RX_PERIODIC: out_ch.ready <= ((rx_phase % 7) < 3);
                default:     out_ch.ready <= ($urandom_range(0, 7) == 0);
            endcase
        end
    end

    // Result check: each accepted result against the oldest owed one
    always @(posedge i_clk) begin
        t_out_item want;
        if (i_rst_n === 1'b1 && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
            if (sorted_q.size() == 0) begin
                report_mismatch($sformatf("result with none owed: value=%0d last=%b ovf=%b",
                                          out_ch.data.sorted_value, out_ch.data.last_out,
                                          out_ch.data.overflowed));
            end else begin
                want = sorted_q.pop_front();
                if (out_ch.data.sorted_value !== want.sorted_value)
                    report_mismatch($sformatf("sorted_value got %0d want %0d",
                                              out_ch.data.sorted_value, want.sorted_value));
                if (out_ch.data.last_out !== want.last_out)
                    report_mismatch($sformatf("last_out got %b want %b (value %0d)",
                                              out_ch.data.last_out, want.last_out,
                                              want.sorted_value));
                if (out_ch.data.overflowed !== want.overflowed)
                    report_mismatch($sformatf("overflowed got %b want %b (value %0d)",
                                              out_ch.data.overflowed, want.overflowed,
                                              want.sorted_value));
            end
        end
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Extremes, duplicates, one-element batches, presorted and reversed
    task automatic test_directed();
        t_data vals [$];
        vals = '{S32_MIN};
        send_batch(vals);
        vals = '{S32_MAX};
        send_batch(vals);
        vals = '{S32_MAX, 7, -1, 0, S32_MIN, 7, 1, -7, -1, S32_MAX};
        send_batch(vals);
        vals = '{70, 60, 50, 40, 30, 20, 10, 0};
        send_batch(vals);
        vals = '{-3, -2, -1, 0};
        send_batch(vals);
    endtask

    // Exactly full, then past full with the closing item dropped,
    // then a short batch to see the overflow mark cleared
    task automatic test_overflow();
        t_data vals [$];
        fill_random(vals, CAPACITY, VAL_FULL);
        send_batch(vals);
        fill_random(vals, CAPACITY + 3, VAL_DUPS);
        send_batch(vals);
        fill_random(vals, CAPACITY + 1, VAL_FULL);
        send_batch(vals);
        vals = '{5, -5};
        send_batch(vals);
    endtask

    // Output held off for a long stretch while input keeps coming: the
    // block finishes sorting, parks its first result and stops loading.
    task automatic test_backpressure();
        t_data vals [$];
        hold_requests++;
        fill_random(vals, 16, VAL_FULL);
        send_batch(vals);
        fill_random(vals, 12, VAL_DUPS);
        send_batch(vals);
    endtask

    // Sender idles until everything is out, then loads again
    task automatic test_drain_pause();
        t_data vals [$];
        fill_random(vals, 9, VAL_EXTREMES);
        send_batch(vals);
        wait_drained();
        fill_random(vals, 5, VAL_FULL);
        send_batch(vals);
    endtask

    // Mostly small batches, some mid-size, a few full or overfull
    task automatic test_random();
        t_data      vals [$];
        int         sel, n;
        t_val_shape shape;
        while (items_sent < ITEM_GOAL) begin
            sel = $urandom_range(0, 99);
            if (sel < 70)
                n = $urandom_range(1, 8);
            else if (sel < 90)
                n = $urandom_range(9, 32);
            else if (sel < 98)
                n = $urandom_range(33, CAPACITY);
            else
                n = $urandom_range(CAPACITY + 1, CAPACITY + 8);
            shape = t_val_shape'($urandom_range(0, 4));
            fill_random(vals, n, shape);
            send_batch(vals);
            if ($urandom_range(0, 7) == 0)
                wait_drained();
        end
    endtask

    // Watchdog
    initial begin
        int cycle_count;
        cycle_count = 0;
        while (cycle_count < LIMIT_CYC) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("FAIL merge_sort_array_top");
        $finish;
    end

    initial begin
        in_ch.valid  = 1'b0;
        in_ch.data   = '0;
        out_ch.ready = 1'b0;
        i_rst_n      = 1'b0;
        repeat (RESET_CYC) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed();
        test_overflow();
        test_backpressure();
        test_drain_pause();
        test_random();

        // Everything owed has come; watch a while longer for strays
        wait_drained();
        repeat (DRAIN_CYC) @(posedge i_clk);

        if (err_count == 0)
            $display("PASS merge_sort_array_top");
        else
            $display("FAIL merge_sort_array_top");
        $finish;
    end

endmodule

/* sim.f */
rtl/msa_pkg.sv
rtl/msa_if.sv
rtl/msa_bank.sv
rtl/merge_sort_array_top.sv
tb/sv/tb_merge_sort_array_top.sv
